// File: design/sclp_pkg.sv
// Shared types, constants and character helpers for the serial command line parser.
package sclp_pkg;

   localparam int LINE_BYTES_DEF = 32;
   localparam logic [31:0] TIMEOUT_RESET = 32'd1000000;

   localparam int NUM_KW = 10;
   localparam int KW_MAX_LEN = 10;
   localparam int KW_LIBRARY_WRITE = 3;
   localparam int KW_WRITE = 4;

   typedef enum logic [3:0] {
      CODE_BLANK         = 4'd0,
      CODE_RESET         = 4'd1,
      CODE_EXECUTE       = 4'd2,
      CODE_WRITE         = 4'd3,
      CODE_LIBRARY_WRITE = 4'd4,
      CODE_CLEAR         = 4'd5,
      CODE_HELP          = 4'd6,
      CODE_VERSION       = 4'd7,
      CODE_SHOWPROG      = 4'd8,
      CODE_VERIFY        = 4'd9,
      CODE_ILLEGAL       = 4'd10,
      CODE_TIMEOUT       = 4'd11
   } result_code_type;

   typedef enum logic [7:0] {
      PH_IDLE     = 8'b0000_0001,
      PH_PRE_SIZE = 8'b0000_0010,
      PH_SIGN     = 8'b0000_0100,
      PH_SIZE     = 8'b0000_1000,
      PH_PRE_CRC  = 8'b0001_0000,
      PH_ZERO     = 8'b0010_0000,
      PH_HEX      = 8'b0100_0000,
      PH_DONE     = 8'b1000_0000
   } arg_phase_type;

   typedef struct packed {
      arg_phase_type phase;
      logic [31:0]   size_accum;
      logic          size_neg;
      logic          size_seen;
      logic [31:0]   crc_accum;
      logic          crc_seen;
   } arg_state_type;

   localparam logic [7:0] CHAR_LF = 8'h0a;
   localparam logic [7:0] CHAR_CR = 8'h0d;
   localparam logic [7:0] CHAR_NUL = 8'h00;

   // Keyword text, right aligned: the last character sits in the low byte.
   localparam logic [8*KW_MAX_LEN-1:0] KW_TEXT [NUM_KW] = '{
      80'({CHAR_CR, CHAR_LF}),
      80'({"reset", CHAR_CR, CHAR_LF}),
      80'({"execute", CHAR_CR, CHAR_LF}),
      80'("write_lib "),
      80'("write "),
      80'({"clear", CHAR_CR, CHAR_LF}),
      80'({"help", CHAR_CR, CHAR_LF}),
      80'({"version", CHAR_CR, CHAR_LF}),
      80'({"showprog", CHAR_CR, CHAR_LF}),
      80'({"verify", CHAR_CR, CHAR_LF})
   };
   localparam int KW_LEN [NUM_KW] = '{2, 7, 9, 10, 6, 7, 6, 9, 10, 8};
   localparam result_code_type KW_CODE [NUM_KW] = '{
      CODE_BLANK, CODE_RESET, CODE_EXECUTE, CODE_LIBRARY_WRITE, CODE_WRITE,
      CODE_CLEAR, CODE_HELP, CODE_VERSION, CODE_SHOWPROG, CODE_VERIFY
   };

   function automatic logic [7:0] kw_char(input int k, input int p);
      int sh;
      sh = 8 * (KW_LEN[k] - 1 - p);
      if (p >= KW_LEN[k] || sh < 0) begin
         return 8'h00;
      end
      return KW_TEXT[k][sh +: 8];
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || (c inside {[8'h09:8'h0d]});
   endfunction

   function automatic logic is_dec(input logic [7:0] c);
      return c inside {["0":"9"]};
   endfunction

   // Hex digit value in the low four bits; bit 4 set when c is not a hex digit.
   function automatic logic [4:0] hex_val(input logic [7:0] c);
      logic [7:0] d;
      d = 8'h00;
      if (c inside {["0":"9"]}) begin
         d = c - 8'h30;
      end else if (c inside {["a":"f"]}) begin
         d = c - 8'h57;
      end else if (c inside {["A":"F"]}) begin
         d = c - 8'h37;
      end else begin
         d = 8'h10;
      end
      return d[4:0];
   endfunction

endpackage

// File: design/sclp_arg_step.sv
// Next state of the write-command argument scanner for one received byte.
module sclp_arg_step (
   input  sclp_pkg::arg_state_type cur,
   input  logic [7:0]              rx_byte,
   output sclp_pkg::arg_state_type nxt
);
   import sclp_pkg::*;

   logic [4:0]  hex_d;
   logic [31:0] size_times_ten;
   logic [31:0] dec_d;
   arg_state_type crc_start;
   arg_state_type hex_step;

   assign hex_d = hex_val(rx_byte);
   assign dec_d = {28'd0, rx_byte[3:0]};
   assign size_times_ten = {cur.size_accum[28:0], 3'b000} + {cur.size_accum[30:0], 1'b0};

   always_comb begin
      crc_start = cur;
      if (rx_byte == "0") begin
         crc_start.crc_seen = 1'b1;
         crc_start.phase = PH_ZERO;
      end else if (!hex_d[4]) begin
         crc_start.crc_accum = {28'd0, hex_d[3:0]};
         crc_start.crc_seen = 1'b1;
         crc_start.phase = PH_HEX;
      end else begin
         crc_start.phase = PH_DONE;
      end
   end

   always_comb begin
      hex_step = cur;
      if (!hex_d[4]) begin
         hex_step.crc_accum = {cur.crc_accum[27:0], hex_d[3:0]};
         hex_step.phase = PH_HEX;
      end else begin
         hex_step.phase = PH_DONE;
      end
   end

   always_comb begin
      nxt = cur;
      if (cur.phase != PH_IDLE) begin
         if (rx_byte == CHAR_NUL) begin
            nxt.phase = PH_DONE;
         end else begin
            case (cur.phase)
               PH_PRE_SIZE, PH_SIGN: begin
                  if (cur.phase == PH_PRE_SIZE && is_space(rx_byte)) begin
                     nxt.phase = PH_PRE_SIZE;
                  end else if (cur.phase == PH_PRE_SIZE && (rx_byte == "+" || rx_byte == "-")) begin
                     nxt.size_neg = (rx_byte == "-");
                     nxt.phase = PH_SIGN;
                  end else if (is_dec(rx_byte)) begin
                     nxt.size_accum = dec_d;
                     nxt.size_seen = 1'b1;
                     nxt.phase = PH_SIZE;
                  end else begin
                     nxt.phase = PH_DONE;
                  end
               end
               PH_SIZE: begin
                  if (is_dec(rx_byte)) begin
                     nxt.size_accum = size_times_ten + dec_d;
                  end else if (is_space(rx_byte)) begin
                     nxt.phase = PH_PRE_CRC;
                  end else begin
                     nxt = crc_start;
                  end
               end
               PH_PRE_CRC: begin
                  if (!is_space(rx_byte)) begin
                     nxt = crc_start;
                  end
               end
               PH_ZERO: begin
                  if (rx_byte == "x" || rx_byte == "X") begin
                     nxt.phase = PH_HEX;
                  end else begin
                     nxt = hex_step;
                  end
               end
               PH_HEX: begin
                  nxt = hex_step;
               end
               default: begin
                  nxt = cur;
               end
            endcase
         end
      end
   end

endmodule

// File: design/serial_command_line_parser_unit.sv
// Serial command line parser: one item per cycle, result in an output register.
// A result is registered and appears on rsp in the cycle after the beat that ends the line or times out.
// Throughput: one input beat per cycle; each byte is matched and scanned in a single pass.
// The input is stalled only while a finished result waits in the output register.
// Reset (synchronous, active high) clears the line state, empties the output register
// and sets the timeout to 1000000 ticks. No clearing pass is needed.
module serial_command_line_parser_unit #(
   parameter int LINE_BYTES = sclp_pkg::LINE_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   input  logic        req_tuser,   // [0] cmd
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] size_value, [63:32] crc_value
   output logic [4:0]  rsp_tuser,   // [3:0] result_code, [4] crc_given
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import sclp_pkg::*;

   localparam int CNT_W = $clog2(LINE_BYTES);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [NUM_KW-1:0] alive_ff, alive_in, alive_upd;
   arg_state_type     arg_ff, arg_in, arg_upd;
   logic [31:0]       idle_ff, idle_in;
   logic [31:0]       timeout_ff, timeout_in;

   logic              rsp_valid_ff, rsp_valid_in;
   result_code_type   rsp_code_ff, rsp_code_in;
   logic [31:0]       rsp_size_ff, rsp_size_in;
   logic              rsp_crc_given_ff, rsp_crc_given_in;
   logic [31:0]       rsp_crc_ff, rsp_crc_in;

   logic              beat;
   logic              is_tick;
   logic              tick_expired;
   logic [CNT_W:0]    p_plus1;
   logic              line_end;
   logic              enter_args;
   logic              fire;
   result_code_type   kw_result;
   result_code_type   res_code;
   logic [31:0]       res_size;
   logic              res_crc_given;
   logic [31:0]       res_crc;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign beat = req_tvalid && req_tready;
   assign is_tick = req_tuser;
   assign tick_expired = ({1'b0, idle_ff} + 33'd1) >= {1'b0, timeout_ff};
   assign p_plus1 = (CNT_W + 1)'(count_ff) + (CNT_W + 1)'(1);
   assign line_end = (req_tdata == CHAR_LF) || (p_plus1 == (CNT_W + 1)'(LINE_BYTES));

   sclp_arg_step u_arg_step (
      .cur     (arg_ff),
      .rx_byte (req_tdata),
      .nxt     (arg_upd)
   );

   // A keyword drops out on the first mismatching character within its length.
   always_comb begin
      for (int k = 0; k < NUM_KW; k++) begin
         alive_upd[k] = alive_ff[k] &&
            !((int'(count_ff) < KW_LEN[k]) && (kw_char(k, int'(count_ff)) != req_tdata));
      end
   end

   assign enter_args = (arg_upd.phase == PH_IDLE) &&
      ((alive_upd[KW_LIBRARY_WRITE] && (int'(p_plus1) == KW_LEN[KW_LIBRARY_WRITE])) ||
       (alive_upd[KW_WRITE] && (int'(p_plus1) == KW_LEN[KW_WRITE])));

   // The first surviving keyword in table order that is fully received wins.
   always_comb begin
      kw_result = CODE_ILLEGAL;
      for (int k = NUM_KW - 1; k >= 0; k--) begin
         if (alive_upd[k] && (int'(p_plus1) >= KW_LEN[k])) begin
            kw_result = KW_CODE[k];
         end
      end
   end

   always_comb begin
      res_code = kw_result;
      res_size = 32'd0;
      res_crc_given = 1'b0;
      res_crc = 32'd0;
      if (is_tick) begin
         res_code = CODE_TIMEOUT;
      end else if (kw_result == CODE_WRITE || kw_result == CODE_LIBRARY_WRITE) begin
         if (arg_upd.size_seen) begin
            res_size = arg_upd.size_neg ? (32'd0 - arg_upd.size_accum) : arg_upd.size_accum;
            res_crc_given = arg_upd.crc_seen;
            res_crc = arg_upd.crc_seen ? arg_upd.crc_accum : 32'd0;
         end else begin
            res_code = CODE_ILLEGAL;
         end
      end
   end

   assign fire = beat && (is_tick ? tick_expired : line_end);

   always_comb begin
      count_in = count_ff;
      alive_in = alive_ff;
      arg_in = arg_ff;
      idle_in = idle_ff;
      timeout_in = csr_wr_en ? csr_wr_data : timeout_ff;
      if (beat) begin
         if (fire) begin
            count_in = '0;
            alive_in = '1;
            arg_in = '{phase: PH_IDLE, default: '0};
            idle_in = 32'd0;
         end else if (is_tick) begin
            idle_in = idle_ff + 32'd1;
         end else begin
            count_in = p_plus1[CNT_W-1:0];
            alive_in = alive_upd;
            arg_in = arg_upd;
            if (enter_args) begin
               arg_in.phase = PH_PRE_SIZE;
            end
            idle_in = 32'd0;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_code_in = rsp_code_ff;
      rsp_size_in = rsp_size_ff;
      rsp_crc_given_in = rsp_crc_given_ff;
      rsp_crc_in = rsp_crc_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
         rsp_code_in = res_code;
         rsp_size_in = res_size;
         rsp_crc_given_in = res_crc_given;
         rsp_crc_in = res_crc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         alive_ff <= '1;
         arg_ff <= '{phase: PH_IDLE, default: '0};
         idle_ff <= 32'd0;
         timeout_ff <= TIMEOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         alive_ff <= alive_in;
         arg_ff <= arg_in;
         idle_ff <= idle_in;
         timeout_ff <= timeout_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_code_ff <= rsp_code_in;
      rsp_size_ff <= rsp_size_in;
      rsp_crc_given_ff <= rsp_crc_given_in;
      rsp_crc_ff <= rsp_crc_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {rsp_crc_ff, rsp_size_ff};
   assign rsp_tuser = {rsp_crc_given_ff, rsp_code_ff};

endmodule

// File: design/sclp_checker.sv
// Port-level checks for the serial command line parser, bound to the top level.
module sclp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [63:0] rsp_tdata,
   input logic [4:0]  rsp_tuser
);
   import sclp_pkg::*;

   // A result that is not taken stays put.
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result beat changed while stalled");

   a_code_range : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser[3:0] <= CODE_TIMEOUT)
      else $error("result code out of range");

   // Only write commands carry arguments.
   a_args_only_write : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[3:0] != CODE_WRITE && rsp_tuser[3:0] != CODE_LIBRARY_WRITE
      |-> rsp_tdata == 64'd0 && !rsp_tuser[4])
      else $error("argument fields set on a non-write result");

   a_crc_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[4] |-> rsp_tdata[63:32] == 32'd0)
      else $error("checksum value without checksum flag");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present right after reset");

endmodule

bind serial_command_line_parser_unit sclp_checker u_sclp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// File: tb/testbench.sv
// Self-checking testbench for the serial command line parser: directed lines, then random traffic.
`timescale 1ns / 100ps

module testbench;
   import sclp_pkg::*;

   localparam int LINE_LEN = 32;
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef struct packed {
      result_code_type code;
      logic [31:0]     size;
      logic            crc_given;
      logic [31:0]     crc;
   } line_result_type;

   // Tracks the parser state per accepted beat and holds the line results still owed.
   class command_line_tracker;
      logic [31:0]     timeout_ticks;
      int unsigned     byte_count;
      logic [10:0]     kw_alive;
      arg_phase_type   phase;
      logic [31:0]     size_acc;
      logic            size_neg;
      logic            size_seen;
      logic [31:0]     crc_acc;
      logic            crc_seen;
      logic [31:0]     idle_ticks;
      line_result_type pending_results[$];
      int              mismatches;

      function new();
         timeout_ticks = 32'd1000000;
         mismatches = 0;
         clear_line();
      endfunction

      function void clear_line();
         byte_count = 0;
         kw_alive = '1;
         phase = PH_IDLE;
         size_acc = '0;
         size_neg = 1'b0;
         size_seen = 1'b0;
         crc_acc = '0;
         crc_seen = 1'b0;
         idle_ticks = '0;
      endfunction

      static function string keyword_text(int k);
         case (k)
            0: return "\015\012";
            1: return "reset\015\012";
            2: return "execute\015\012";
            3: return "write_lib ";
            4: return "write ";
            5: return "clear\015\012";
            6: return "help\015\012";
            7: return "version\015\012";
            8: return "showprog\015\012";
            default: return "verify\015\012";
         endcase
      endfunction

      static function result_code_type keyword_code(int k);
         case (k)
            0: return CODE_BLANK;
            1: return CODE_RESET;
            2: return CODE_EXECUTE;
            3: return CODE_LIBRARY_WRITE;
            4: return CODE_WRITE;
            5: return CODE_CLEAR;
            6: return CODE_HELP;
            7: return CODE_VERSION;
            8: return CODE_SHOWPROG;
            default: return CODE_VERIFY;
         endcase
      endfunction

      function bit is_ws(logic [7:0] c);
         return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      // Returns 16 for a byte that is not a hex digit.
      function int hex_value(logic [7:0] c);
         if (is_digit(c)) return int'(c) - 48;
         if (c >= "a" && c <= "f") return int'(c) - 87;
         if (c >= "A" && c <= "F") return int'(c) - 55;
         return 16;
      endfunction

      function void first_size_digit(logic [7:0] c);
         if (is_digit(c)) begin
            size_acc = 32'(c - 8'h30);
            size_seen = 1'b1;
            phase = PH_SIZE;
         end else begin
            phase = PH_DONE;
         end
      endfunction

      // A leading zero may still turn into a 0x prefix, so it waits in its own phase.
      function void start_checksum(logic [7:0] c);
         int v;
         v = hex_value(c);
         if (c == "0") begin
            crc_seen = 1'b1;
            phase = PH_ZERO;
         end else if (v < 16) begin
            crc_acc = 32'(v);
            crc_seen = 1'b1;
            phase = PH_HEX;
         end else begin
            phase = PH_DONE;
         end
      endfunction

      function void hex_step(logic [7:0] c);
         int v;
         v = hex_value(c);
         if (v < 16) begin
            crc_acc = {crc_acc[27:0], 4'(v)};
            phase = PH_HEX;
         end else begin
            phase = PH_DONE;
         end
      endfunction

      function void scan_argument(logic [7:0] c);
         if (c == 8'h00) begin
            phase = PH_DONE;
            return;
         end
         case (phase)
            PH_PRE_SIZE: begin
               if (!is_ws(c)) begin
                  if (c == "+" || c == "-") begin
                     size_neg = (c == "-");
                     phase = PH_SIGN;
                  end else begin
                     first_size_digit(c);
                  end
               end
            end
            PH_SIGN: first_size_digit(c);
            PH_SIZE: begin
               if (is_digit(c)) begin
                  size_acc = size_acc * 32'd10 + 32'(c - 8'h30);
               end else if (is_ws(c)) begin
                  phase = PH_PRE_CRC;
               end else begin
                  start_checksum(c);
               end
            end
            PH_PRE_CRC: begin
               if (!is_ws(c)) start_checksum(c);
            end
            PH_ZERO: begin
               if (c == "x" || c == "X") begin
                  phase = PH_HEX;
               end else begin
                  hex_step(c);
               end
            end
            PH_HEX: hex_step(c);
            default: ;
         endcase
      endfunction

      function void note_beat(bit cmd, logic [7:0] c);
         int unsigned     p;
         bit              found;
         string           kw;
         line_result_type res;
         logic [31:0]     next_idle;
         res = '0;
         if (cmd) begin
            next_idle = idle_ticks + 32'd1;
            if (next_idle >= timeout_ticks) begin
               clear_line();
               res.code = CODE_TIMEOUT;
               pending_results.push_back(res);
            end else begin
               idle_ticks = next_idle;
            end
            return;
         end
         p = byte_count;
         idle_ticks = '0;
         if (phase != PH_IDLE) scan_argument(c);
         for (int k = 0; k < NUM_KW; k++) begin
            kw = keyword_text(k);
            if (p < kw.len() && kw[p] != c) kw_alive[k] = 1'b0;
         end
         if (phase == PH_IDLE) begin
            if (kw_alive[3] && p + 1 == keyword_text(3).len()) phase = PH_PRE_SIZE;
            if (kw_alive[4] && p + 1 == keyword_text(4).len()) phase = PH_PRE_SIZE;
         end
         if (c != 8'h0a && p + 1 < LINE_LEN) begin
            byte_count = p + 1;
            return;
         end
         res.code = CODE_ILLEGAL;
         found = 1'b0;
         for (int k = 0; k < NUM_KW; k++) begin
            if (!found && kw_alive[k] && p + 1 >= keyword_text(k).len()) begin
               res.code = keyword_code(k);
               found = 1'b1;
            end
         end
         if (res.code == CODE_WRITE || res.code == CODE_LIBRARY_WRITE) begin
            if (size_seen) begin
               res.size = size_neg ? 32'd0 - size_acc : size_acc;
               res.crc_given = crc_seen;
               res.crc = crc_seen ? crc_acc : 32'd0;
            end else begin
               res.code = CODE_ILLEGAL;
            end
         end
         pending_results.push_back(res);
         clear_line();
      endfunction

      function void check_response(line_result_type got);
         line_result_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: code=%0d size=%h crc_given=%0b crc=%h",
                        got.code, got.size, got.crc_given, got.crc);
            return;
         end
         want = pending_results.pop_front();
         if (got.code !== want.code || got.size !== want.size ||
             got.crc_given !== want.crc_given || got.crc !== want.crc) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected code=%0d size=%h crc_given=%0b crc=%h, ",
                         "got code=%0d size=%h crc_given=%0b crc=%h"},
                        want.code, want.size, want.crc_given, want.crc,
                        got.code, got.size, got.crc_given, got.crc);
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic        req_tuser = 1'b0;    // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;           // [31:0] size_value, [63:32] crc_value
   logic [4:0]  rsp_tuser;           // [3:0] result_code, [4] crc_given
   logic        csr_wr_en = 1'b0;
   logic [31:0] csr_wr_data = 32'd0;

   command_line_tracker tracker = new();
   int          send_idle_pct = 28;
   int          recv_idle_pct = 76;
   int unsigned beats_sent = 0;
   int unsigned cycle_count = 0;
   logic [31:0] timeout_now = 32'd1000000;
   logic [7:0]  line_q[$];

   serial_command_line_parser_unit #(.LINE_BYTES(LINE_LEN)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL serial_command_line_parser_unit");
         $finish;
      end
   end

   // Result side: check each accepted beat, then pick the ready level for the next edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_response(line_result_type'{result_code_type'(rsp_tuser[3:0]),
                                                   rsp_tdata[31:0], rsp_tuser[4],
                                                   rsp_tdata[63:32]});
      rsp_tready <= (recv_idle_pct == 0) || ($urandom_range(0, 99) >= recv_idle_pct);
   end

   task automatic send_beat(input bit cmd, input logic [7:0] b);
      while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= b;
      do @(posedge clock); while (req_tready !== 1'b1);
      tracker.note_beat(cmd, b);
      beats_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_beat(1'b0, s[i]);
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_beat(1'b1, 8'($urandom));
   endtask

   // Short bursts around a small timeout so that both sides of the limit are hit.
   task automatic tick_burst();
      int span;
      span = (timeout_now <= 32'd40) ? int'(timeout_now) + 3 : 8;
      send_ticks($urandom_range(1, span));
   endtask

   // The register only changes once the parser has nothing in flight.
   task automatic write_timeout(input logic [31:0] value);
      req_tvalid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      tracker.timeout_ticks = value;
      timeout_now = value;
   endtask

   function automatic void add_text(input string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endfunction

   function automatic logic [7:0] rand_space();
      case ($urandom_range(0, 4))
         0: return 8'h09;
         1: return 8'h0b;
         2: return 8'h0c;
         3: return 8'h0d;
         default: return 8'h20;
      endcase
   endfunction

   function automatic logic [7:0] rand_hex_char();
      string digits;
      digits = "0123456789abcdefABCDEF";
      return digits[$urandom_range(0, 21)];
   endfunction

   function automatic void build_write();
      int form;
      if ($urandom_range(0, 1)) add_text("write_lib ");
      else add_text("write ");
      repeat ($urandom_range(0, 2)) line_q.push_back(rand_space());
      form = $urandom_range(0, 9);
      if (form < 2) line_q.push_back("+");
      else if (form < 4) line_q.push_back("-");
      repeat (($urandom_range(0, 11) == 0) ? 0 : $urandom_range(1, 12))
         line_q.push_back(8'h30 + 8'($urandom_range(0, 9)));
      repeat ($urandom_range(0, 2)) line_q.push_back(rand_space());
      case ($urandom_range(0, 5))
         0: ;
         1, 2: repeat ($urandom_range(1, 10)) line_q.push_back(rand_hex_char());
         3: begin
            add_text("0x");
            repeat ($urandom_range(1, 10)) line_q.push_back(rand_hex_char());
         end
         4: begin
            add_text("0X");
            repeat ($urandom_range(1, 10)) line_q.push_back(rand_hex_char());
         end
         default: add_text("0x");
      endcase
      if ($urandom_range(0, 4) == 0) begin
         if ($urandom_range(0, 2) == 0) line_q.push_back(8'h00);
         repeat ($urandom_range(1, 3)) line_q.push_back(8'($urandom_range(0, 255)));
      end
      form = $urandom_range(0, 9);
      if (form < 7) begin
         add_text("\015\n");
      end else if (form < 9) begin
         line_q.push_back(8'h0a);
      end else begin
         // No line feed: the line is cut at its full length.
         repeat (LINE_LEN) line_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
      end
   endfunction

   task automatic gen_line();
      int kind;
      int k;
      line_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 15) begin
         k = $urandom_range(0, 7);
         if (k >= 3) k += 2;
         add_text(command_line_tracker::keyword_text(k));
         if ($urandom_range(0, 3) == 0)
            line_q[$urandom_range(0, line_q.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind < 70) begin
         build_write();
      end else if (kind < 88) begin
         repeat ($urandom_range(1, 40)) line_q.push_back(8'($urandom_range(0, 255)));
         if ($urandom_range(0, 1)) line_q.push_back(8'h0a);
      end else begin
         tick_burst();
         return;
      end
      foreach (line_q[i]) begin
         if ($urandom_range(0, 99) < 4) tick_burst();
         send_beat(1'b0, line_q[i]);
      end
   endtask

   logic [31:0] seg_timeout [6] = '{32'hffff_ffff, 32'd5, 32'd0, 32'd1, 32'd17, 32'd1000000};

   initial begin
      int unsigned target;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Every keyword that takes no argument, then the argument corner cases, with the reset timeout.
      for (int k = 0; k < NUM_KW; k++) begin
         if (k == 3 || k == 4) continue;
         send_text(command_line_tracker::keyword_text(k));
      end
      send_text("write 0\015\n");
      send_text("write_lib -4294967295 0xFFFFFFFF\015\n");
      send_text("write +12 abc\015\n");
      send_text("write 4294967296 0X00000000\n");
      send_text("write 12ab\n");
      send_text("write 5 0x\n");
      send_text("write \t\n");
      send_text("write -\n");
      send_text("write 7");
      send_beat(1'b0, 8'h00);
      send_text(" ff\n");
      send_text("write_lib 9 zz\n");
      send_text("reset\n");
      send_text("\n");
      send_beat(1'b0, 8'hff);
      send_beat(1'b0, 8'h00);
      send_text("\n");
      repeat (40) send_beat(1'b0, "a");
      send_text("\n");
      send_ticks(3);
      // A partial line dropped by an idle timeout.
      write_timeout(32'd2);
      send_text("hel");
      send_ticks(3);
      send_text("p\015\n");

      for (int seg = 0; seg < 6; seg++) begin
         send_idle_pct = (seg < 2) ? 28 : (seg < 4) ? 76 : 0;
         recv_idle_pct = (seg < 2) ? 76 : (seg < 4) ? 28 : 0;
         write_timeout(seg_timeout[seg]);
         target = beats_sent + 150;
         while (beats_sent < target) gen_line();
      end

      req_tvalid <= 1'b0;
      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
         $display("PASS serial_command_line_parser_unit");
      end else begin
         $display("FAIL serial_command_line_parser_unit");
      end
      $finish;
   end

endmodule
